/* hdl/mhpq_pkg.sv */
// shared types and codes for the min-heap priority queue
// used by mhpq_ctrl, mhpq_dpath, the top level and the checker
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 128;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_MODIFY = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_insert;
        logic start_modify;
        logic rd_slot;
        logic rd_parent;
        logic rd_left;
        logic rd_right;
        logic up_move;
        logic write_key;
        logic cand_load;
        logic dn_move;
        logic dn_right;
        logic set_full;
        logic set_bad;
        logic set_value;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       slot_ok;
        logic       pos_root;
        logic       parent_gt;
        logic       left_exists;
        logic       right_exists;
        logic       best_l_valid;
        logic       best_b_valid;
        logic       first;
        logic       out_busy;
    } t_dp_stat;

endpackage

/* hdl/mhpq_ctrl.sv */
// controller state machine for the min-heap priority queue
// sequences slot reads, sift-up and sift-down steps; depends on mhpq_pkg
`timescale 1ns / 1ps
module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mhpq_pkg::t_dp_stat i_stat,
    output mhpq_pkg::t_dp_cmd  o_cmd
);
    import mhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                case (i_stat.req)
                    REQ_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.set_full = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.start_insert = 1'b1;
                            n_state            = S_UP_RD;
                        end
                    end
                    REQ_MODIFY: begin
                        if (!i_stat.slot_ok) begin
                            o_cmd.set_bad = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.start_modify = 1'b1;
                            n_state            = S_UP_RD;
                        end
                    end
                    REQ_READ: begin
                        if (!i_stat.slot_ok) begin
                            o_cmd.set_bad = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.rd_slot = 1'b1;
                            n_state       = S_RD_WAIT;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD_WAIT: begin
                o_cmd.set_value = 1'b1;
                n_state         = S_DONE;
            end
            S_UP_RD: begin
                if (i_stat.pos_root) begin
                    if (i_stat.first) begin
                        n_state = S_DN_RDL;
                    end else begin
                        o_cmd.write_key = 1'b1;
                        n_state         = S_DONE;
                    end
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.parent_gt) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else if (i_stat.first) begin
                    // modified key not below its parent: go down instead
                    n_state = S_DN_RDL;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DN_RDL: begin
                if (i_stat.left_exists) begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_DN_RDR;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DN_RDR: begin
                if (i_stat.right_exists) begin
                    o_cmd.cand_load = 1'b1;
                    o_cmd.rd_right  = 1'b1;
                    n_state         = S_DN_CMP;
                end else begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = i_stat.best_l_valid ? S_DN_RDL : S_DONE;
                end
            end
            S_DN_CMP: begin
                o_cmd.dn_move  = 1'b1;
                o_cmd.dn_right = 1'b1;
                n_state        = i_stat.best_b_valid ? S_DN_RDL : S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* hdl/mhpq_dpath.sv */
// datapath for the min-heap priority queue: key store, moving key,
// position and count registers, output register; depends on mhpq_pkg
`timescale 1ns / 1ps
module mhpq_dpath #(
    parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mhpq_pkg::t_dp_cmd  i_cmd,
    output mhpq_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [7:0]         i_slot,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_count,
    output logic [1:0]         o_status
);
    import mhpq_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = $clog2(2 * CAPACITY + 2);
    localparam int CMPW = (PW > 8) ? PW : 8;

    logic signed [31:0] r_mem [CAPACITY];

    logic [1:0]         r_req;
    logic signed [31:0] r_key;
    logic [7:0]         r_slot;
    logic [PW-1:0]      r_pos;
    logic [CW-1:0]      r_count;
    logic               r_first;
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_cand_key;
    logic [PW-1:0]      r_cand_pos;
    logic               r_cand_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_value;
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [7:0]         r_out_count;
    logic [1:0]         r_out_status;

    logic [CMPW-1:0]    slot_w;
    logic [CMPW-1:0]    count_w;
    logic [PW-1:0]      count_p;
    logic [PW-1:0]      parent_pos;
    logic [PW-1:0]      left_pos;
    logic [PW-1:0]      right_pos;
    logic [PW-1:0]      rd_pos;
    logic [PW-1:0]      rd_pos_m1;
    logic [PW-1:0]      wr_pos_m1;
    logic               rd_en;
    logic               wr_en;
    logic signed [31:0] wr_data;
    logic               right_better;
    logic               best_l_valid;
    logic               best_b_valid;
    logic               best_valid;
    logic signed [31:0] best_key;
    logic [PW-1:0]      best_pos;

    assign slot_w     = CMPW'(r_slot);
    assign count_w    = CMPW'(r_count);
    assign count_p    = PW'(r_count);
    assign parent_pos = r_pos >> 1;
    assign left_pos   = {r_pos[PW-2:0], 1'b0};
    assign right_pos  = {r_pos[PW-2:0], 1'b1};

    // child selection for sift-down, ties never move
    assign best_l_valid = r_rdata < r_key;
    assign right_better = r_rdata < (r_cand_valid ? r_cand_key : r_key);
    assign best_b_valid = r_cand_valid || right_better;

    always_comb begin
        if (i_cmd.dn_right) begin
            best_valid = best_b_valid;
            best_key   = right_better ? r_rdata : r_cand_key;
            best_pos   = right_better ? right_pos : r_cand_pos;
        end else begin
            best_valid = best_l_valid;
            best_key   = r_rdata;
            best_pos   = left_pos;
        end
    end

    always_comb begin
        rd_pos = parent_pos;
        if (i_cmd.rd_slot) begin
            rd_pos = slot_w[PW-1:0];
        end else if (i_cmd.rd_left) begin
            rd_pos = left_pos;
        end else if (i_cmd.rd_right) begin
            rd_pos = right_pos;
        end
    end
    assign rd_en     = i_cmd.rd_slot | i_cmd.rd_parent | i_cmd.rd_left | i_cmd.rd_right;
    assign rd_pos_m1 = rd_pos - PW'(1);
    assign wr_pos_m1 = r_pos - PW'(1);

    always_comb begin
        wr_en   = i_cmd.up_move | i_cmd.write_key | i_cmd.dn_move;
        wr_data = r_key;
        if (i_cmd.up_move) begin
            wr_data = r_rdata;
        end else if (i_cmd.dn_move && best_valid) begin
            wr_data = best_key;
        end
    end

    // key store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_pos_m1[IW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_pos_m1[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_insert) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req_type;
            r_key    <= i_key;
            r_slot   <= i_slot;
            r_status <= ST_OK;
            r_value  <= '0;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.set_bad) begin
            r_status <= ST_BAD_SLOT;
        end
        if (i_cmd.set_value) begin
            r_value <= r_rdata;
        end
        if (i_cmd.start_insert) begin
            r_pos   <= count_p + PW'(1);
            r_first <= 1'b0;
        end
        if (i_cmd.start_modify) begin
            r_pos   <= slot_w[PW-1:0];
            r_first <= 1'b1;
        end
        if (i_cmd.up_move) begin
            r_pos   <= parent_pos;
            r_first <= 1'b0;
        end
        if (i_cmd.dn_move && best_valid) begin
            r_pos <= best_pos;
        end
        if (i_cmd.cand_load) begin
            r_cand_valid <= best_l_valid;
            r_cand_key   <= r_rdata;
            r_cand_pos   <= left_pos;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_value;
            r_out_count  <= count_w[7:0];
            r_out_status <= r_status;
        end
    end

    assign o_stat.req          = r_req;
    assign o_stat.full         = (r_count == CW'(CAPACITY));
    assign o_stat.slot_ok      = (r_slot != 8'd0) && (slot_w <= count_w);
    assign o_stat.pos_root     = (r_pos == PW'(1));
    assign o_stat.parent_gt    = r_rdata > r_key;
    assign o_stat.left_exists  = left_pos <= count_p;
    assign o_stat.right_exists = right_pos <= count_p;
    assign o_stat.best_l_valid = best_l_valid;
    assign o_stat.best_b_valid = best_b_valid;
    assign o_stat.first        = r_first;
    assign o_stat.out_busy     = r_out_valid && i_stall;

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_count  = r_out_count;
    assign o_status = r_out_status;

endmodule

/* hdl/min_heap_priority_queue.sv */
// channel   | valid   | stall   | payload
// request   | i_valid | o_stall | i_req_type, i_key, i_slot
// result    | o_valid | i_stall | o_value, o_count, o_status
//
// one request at a time; o_stall is high from acceptance until the result is registered
// one key store read per step sets the pace; rejected or unused requests go to done,
// a read waits once on the key store, an insert or climbing modify reads one parent
// per level climbed, a sinking modify reads left then right child per level descended
// synchronous active-low reset empties the heap; key store contents are not cleared
// a stalled result holds and the next request is still taken behind it
// top level of the min-heap priority queue; depends on mhpq_pkg, mhpq_ctrl, mhpq_dpath
`timescale 1ns / 1ps
module min_heap_priority_queue #(
    parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [7:0]         i_slot,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic [7:0]         o_count,
    output logic [1:0]         o_status
);
    import mhpq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_slot     (i_slot),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_count    (o_count),
        .o_status   (o_status)
    );

endmodule

/* hdl/mhpq_checker.sv */
// port-level checks for min_heap_priority_queue, attached by bind
// depends on mhpq_pkg
`timescale 1ns / 1ps
module mhpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_value,
    input logic [7:0]         o_count,
    input logic [1:0]         o_status
);
    import mhpq_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_count)
            && $stable(o_status))
        else $error("result changed while stalled");

    // an accepted request blocks the next one in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request side not busy after accept");

    // only an ok result carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_value == 32'sd0)
        else $error("nonzero value with failing status");

    // reset leaves both channels idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not idle after reset");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
